// ----- rtl/vplc_pkg.sv -----
// ----------------------------------------------------------------------------
// vplc_pkg
// shared types and constants for the visited point loop closure block
// ----------------------------------------------------------------------------
`default_nettype none

package vplc_pkg;

    localparam int MAX_POINTS_DEF = 64;

    localparam int COORD_W = 16;
    localparam int DIST_W  = 32;
    localparam int RAD_W   = 10;
    localparam int TRAV_W  = 16;
    localparam int CFG_W   = 16;
    localparam int CIDX_W  = 2;

    localparam logic [RAD_W-1:0]  RADIUS_RST = RAD_W'(25);
    localparam logic [TRAV_W-1:0] TRAVEL_RST = TRAV_W'(100);

    // configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_RADIUS = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_TRAVEL = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_SIDE   = 2'd2;

    // item function codes
    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_CHECK = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DRAIN  = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    typedef struct packed {
        logic load;     // latch the item, do the add
        logic scan_rd;  // read the next stored point
        logic finish;   // register the result
    } cmd_t;

    typedef struct packed {
        logic count_zero;
        logic scan_last;
    } status_t;

endpackage

`default_nettype wire

// ----- rtl/vplc_ctrl.sv -----
// ----------------------------------------------------------------------------
// vplc_ctrl
// sequencer: accepts items, walks the scan and drains the compare pipeline
// ----------------------------------------------------------------------------
`default_nettype none

module vplc_ctrl
    import vplc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    input  wire logic    func,
    input  wire status_t status,
    output logic         busy,
    output cmd_t         cmd
);

    // scan pipeline has three stages after the memory read
    localparam logic [1:0] DRAIN_LAST = 2'd2;

    state_t     state_reg, state_next;
    logic [1:0] drain_reg, drain_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            drain_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            drain_reg <= drain_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        drain_next  = drain_reg;
        cmd         = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (func == FUNC_ADD || status.count_zero)
                        state_next = S_FINISH;
                    else
                        state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                if (status.scan_last)
                begin
                    drain_next = '0;
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                drain_next = drain_reg + 2'd1;
                if (drain_reg == DRAIN_LAST)
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

`default_nettype wire

// ----- rtl/vplc_dp.sv -----
// ----------------------------------------------------------------------------
// vplc_dp
// point memory, configuration, distance compare pipeline and result registers
// ----------------------------------------------------------------------------
`default_nettype none

module vplc_dp
    import vplc_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire cmd_t                      cmd,
    output status_t                        status,
    input  wire logic                      func,
    input  wire logic signed [COORD_W-1:0] pos_x,
    input  wire logic signed [COORD_W-1:0] pos_y,
    input  wire logic [DIST_W-1:0]         odometer,
    input  wire logic                      cfg_we,
    input  wire logic [CIDX_W-1:0]         cfg_index,
    input  wire logic [CFG_W-1:0]          cfg_data,
    output logic                           done,
    output logic                           visited,
    output logic                           closed,
    output logic                           table_full,
    output logic [DIST_W-1:0]              last_distance,
    output logic signed [DIST_W:0]         since_last,
    output logic                           side
);

    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int WORD_W = DIST_W + 2 * COORD_W;
    localparam int SQ_W   = 2 * COORD_W;

    // configuration
    logic [RAD_W-1:0]  radius_reg;
    logic [TRAV_W-1:0] travel_reg;
    logic              side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RST;
            travel_reg <= TRAVEL_RST;
            side_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_RADIUS: radius_reg <= cfg_data[RAD_W-1:0];
                CFG_TRAVEL: travel_reg <= cfg_data[TRAV_W-1:0];
                CFG_SIDE:   side_reg   <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    // table state
    logic [CNT_W-1:0]  count_reg;
    logic [DIST_W-1:0] last_reg;
    logic              closed_reg;
    logic              full_reg;
    logic              full_now;
    logic              add_ok;

    assign full_now = (count_reg == CNT_W'(MAX_POINTS));
    assign add_ok   = cmd.load && (func == FUNC_ADD) && !full_now;

    // latched item
    logic signed [COORD_W-1:0] x_reg;
    logic signed [COORD_W-1:0] y_reg;
    logic [DIST_W-1:0]         odo_reg;
    logic [2*RAD_W-1:0]        r2_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg   <= pos_x;
            y_reg   <= pos_y;
            odo_reg <= odometer;
            r2_reg  <= radius_reg * radius_reg;
        end
    end

    // point memory: {dist, y, x}
    logic [WORD_W-1:0] mem [MAX_POINTS];
    logic [WORD_W-1:0] rd_q_reg;
    logic [ADDR_W-1:0] scan_addr_reg;

    always_ff @(posedge clk)
    begin
        if (add_ok)
            mem[count_reg[ADDR_W-1:0]] <= {odometer, pos_y, pos_x};
        if (cmd.scan_rd)
            rd_q_reg <= mem[scan_addr_reg];
    end

    assign status.count_zero = (count_reg == '0);
    assign status.scan_last  = (CNT_W'(scan_addr_reg) == count_reg - CNT_W'(1));

    // compare pipeline
    logic                    v1_reg, v2_reg, v3_reg;
    logic signed [COORD_W:0] dx_reg, dy_reg;
    logic                    trav_ok_reg, trav_ok2_reg;
    logic [SQ_W-1:0]         sqx_reg, sqy_reg;
    logic                    hit_reg;

    logic signed [COORD_W:0]   dx_c, dy_c;
    logic signed [DIST_W:0]    trav_c;
    logic signed [2*COORD_W+1:0] sqx_c, sqy_c;
    logic [SQ_W:0]             sum_c;

    always_comb
    begin
        dx_c   = (COORD_W+1)'(x_reg) - (COORD_W+1)'($signed(rd_q_reg[COORD_W-1:0]));
        dy_c   = (COORD_W+1)'(y_reg)
                 - (COORD_W+1)'($signed(rd_q_reg[2*COORD_W-1:COORD_W]));
        trav_c = $signed({1'b0, odo_reg}) - $signed({1'b0, rd_q_reg[WORD_W-1:2*COORD_W]});
        sqx_c  = dx_reg * dx_reg;
        sqy_c  = dy_reg * dy_reg;
        sum_c  = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.scan_rd;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg       <= dx_c;
        dy_reg       <= dy_c;
        trav_ok_reg  <= (trav_c > $signed({(DIST_W-TRAV_W+1)'(0), travel_reg}));
        sqx_reg      <= sqx_c[SQ_W-1:0];
        sqy_reg      <= sqy_c[SQ_W-1:0];
        trav_ok2_reg <= trav_ok_reg;
    end

    // control state and results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            last_reg      <= '0;
            closed_reg    <= 1'b0;
            full_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            scan_addr_reg <= '0;
            done          <= 1'b0;
        end
        else
        begin
            done <= cmd.finish;
            if (cmd.load)
            begin
                hit_reg       <= 1'b0;
                scan_addr_reg <= '0;
                full_reg      <= (func == FUNC_ADD) && full_now;
            end
            else
            begin
                if (cmd.scan_rd)
                    scan_addr_reg <= scan_addr_reg + ADDR_W'(1);
                if (v3_reg && trav_ok2_reg && (sum_c <= (SQ_W+1)'(r2_reg)))
                    hit_reg <= 1'b1;
            end
            if (add_ok)
            begin
                count_reg <= count_reg + CNT_W'(1);
                last_reg  <= odometer;
            end
            if (cmd.finish && hit_reg)
                closed_reg <= 1'b1;
        end
    end

    // result registers, held for the strobe cycle
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            visited       <= hit_reg;
            closed        <= closed_reg | hit_reg;
            table_full    <= full_reg;
            last_distance <= last_reg;
            since_last    <= $signed({1'b0, odo_reg}) - $signed({1'b0, last_reg});
            side          <= side_reg;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/visited_point_loop_closure.sv -----
// ----------------------------------------------------------------------------
// visited_point_loop_closure
// path point memory with revisit detection for loop closure
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. An add, or a check
// against an empty table, keeps busy high for one cycle in the finish state,
// from which done is registered. A check reads the stored points one per cycle
// from the single-port point memory and then drains a three-stage distance
// pipeline: busy stays high through the scan, the drain and the finish state,
// and done is registered from the finish state. The result ports hold their
// values for the single cycle that done is high; they cannot be held off, so
// the receiver must take each result in that cycle. A new item may be started
// in the done cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module visited_point_loop_closure
    import vplc_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic                      func,
    input  wire logic signed [COORD_W-1:0] pos_x,
    input  wire logic signed [COORD_W-1:0] pos_y,
    input  wire logic [DIST_W-1:0]         odometer,
    input  wire logic                      cfg_we,
    input  wire logic [CIDX_W-1:0]         cfg_index,
    input  wire logic [CFG_W-1:0]          cfg_data,
    output logic                           done,
    output logic                           visited,
    output logic                           closed,
    output logic                           table_full,
    output logic [DIST_W-1:0]              last_distance,
    output logic signed [DIST_W:0]         since_last,
    output logic                           side
);

    cmd_t    cmd;
    status_t status;

    vplc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .func   (func),
        .status (status),
        .busy   (busy),
        .cmd    (cmd)
    );

    vplc_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .func          (func),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .odometer      (odometer),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .done          (done),
        .visited       (visited),
        .closed        (closed),
        .table_full    (table_full),
        .last_distance (last_distance),
        .since_last    (since_last),
        .side          (side)
    );

endmodule

`default_nettype wire

// ----- bench/tb_visited_point_loop_closure.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_visited_point_loop_closure
// self-checking bench for the visited point loop closure block
// ----------------------------------------------------------------------------
// Directed tests cover the empty table, the travel threshold, extreme
// coordinates, the radius boundary and a dropped add on a full table. Random
// traffic then mixes path adds with checks aimed near stored points under
// several register settings. A behavioral copy of the point table predicts
// every result, and each done strobe is compared against the oldest
// prediction.
// ----------------------------------------------------------------------------

module tb_visited_point_loop_closure;

    import vplc_pkg::*;

    localparam int DEPTH = MAX_POINTS_DEF;
    localparam int CYCLE_LIMIT = 1000000;
    localparam logic [CIDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic              visited;
        logic              closed;
        logic              table_full;
        logic [DIST_W-1:0] last_distance;
        logic [DIST_W:0]   since_last;
        logic              side;
    } loop_report_t;

    logic clk = 1'b0;
    logic rst_n;
    logic start;
    logic busy;
    logic func;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic [DIST_W-1:0] odometer;
    logic cfg_we;
    logic [CIDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic done;
    logic visited;
    logic closed;
    logic table_full;
    logic [DIST_W-1:0] last_distance;
    logic signed [DIST_W:0] since_last;
    logic side;

    // predicted block state
    logic signed [COORD_W-1:0] mem_x [DEPTH];
    logic signed [COORD_W-1:0] mem_y [DEPTH];
    logic [DIST_W-1:0] mem_dist [DEPTH];
    int mem_count;
    logic mem_closed;
    logic [RAD_W-1:0] cur_radius;
    logic [TRAV_W-1:0] cur_travel;
    logic cur_side;

    loop_report_t pending_reports [$];
    loop_report_t got_report;
    loop_report_t want_report;

    int mismatches;
    int n_results;
    int n_adds;
    int n_dropped;
    int n_checks;
    int n_hits;
    int cycles;
    bit no_idle;

    // random walk of the robot for well-formed adds
    logic signed [COORD_W-1:0] walk_x;
    logic signed [COORD_W-1:0] walk_y;
    logic [DIST_W-1:0] trip_mm;

    visited_point_loop_closure #(
        .MAX_POINTS (DEPTH)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .func          (func),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .odometer      (odometer),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .done          (done),
        .visited       (visited),
        .closed        (closed),
        .table_full    (table_full),
        .last_distance (last_distance),
        .since_last    (since_last),
        .side          (side)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_reports.size());
            $display("tb_visited_point_loop_closure: errors");
            $finish;
        end
    end

    // applies one item to the point table copy and returns the expected result
    function automatic loop_report_t predict_report(input logic f,
                                                    input logic signed [COORD_W-1:0] x,
                                                    input logic signed [COORD_W-1:0] y,
                                                    input logic [DIST_W-1:0] odo);
        loop_report_t r;
        longint r2;
        longint travel;
        longint dx;
        longint dy;
        longint diff;
        logic [DIST_W-1:0] last;
        bit hit;
        int i;
        r = '0;
        hit = 1'b0;
        if (f == FUNC_ADD)
        begin
            if (mem_count < DEPTH)
            begin
                mem_x[mem_count] = x;
                mem_y[mem_count] = y;
                mem_dist[mem_count] = odo;
                mem_count++;
            end
            else
            begin
                r.table_full = 1'b1;
            end
        end
        else
        begin
            r2 = longint'(cur_radius) * longint'(cur_radius);
            // oldest point first, stop at the first match
            for (i = 0; i < mem_count && !hit; i++)
            begin
                travel = longint'(odo) - longint'(mem_dist[i]);
                if (travel > longint'(cur_travel))
                begin
                    dx = longint'(x) - longint'(mem_x[i]);
                    dy = longint'(y) - longint'(mem_y[i]);
                    if (dx * dx + dy * dy <= r2)
                        hit = 1'b1;
                end
            end
            if (hit)
                mem_closed = 1'b1;
        end
        last = (mem_count > 0) ? mem_dist[mem_count - 1] : '0;
        diff = longint'(odo) - longint'(last);
        r.visited = hit;
        r.closed = mem_closed;
        r.last_distance = last;
        r.since_last = diff[DIST_W:0];
        r.side = cur_side;
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            n_results++;
            got_report.visited = visited;
            got_report.closed = closed;
            got_report.table_full = table_full;
            got_report.last_distance = last_distance;
            got_report.since_last = since_last;
            got_report.side = side;
            if (pending_reports.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result with nothing outstanding: vis=%b cls=%b full=%b last=%h since=%h side=%b",
                             visited, closed, table_full, last_distance, since_last, side);
            end
            else
            begin
                want_report = pending_reports.pop_front();
                if (got_report.visited !== want_report.visited ||
                    got_report.closed !== want_report.closed ||
                    got_report.table_full !== want_report.table_full ||
                    got_report.last_distance !== want_report.last_distance ||
                    got_report.since_last !== want_report.since_last ||
                    got_report.side !== want_report.side)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch on result %0d", n_results);
                        $display("  expected vis=%b cls=%b full=%b last=%h since=%h side=%b",
                                 want_report.visited, want_report.closed,
                                 want_report.table_full, want_report.last_distance,
                                 want_report.since_last, want_report.side);
                        $display("  actual   vis=%b cls=%b full=%b last=%h since=%h side=%b",
                                 got_report.visited, got_report.closed,
                                 got_report.table_full, got_report.last_distance,
                                 got_report.since_last, got_report.side);
                    end
                end
            end
        end
    end

    task automatic send_item(input logic f,
                             input logic signed [COORD_W-1:0] x,
                             input logic signed [COORD_W-1:0] y,
                             input logic [DIST_W-1:0] odo);
        int gap;
        if (!no_idle && $urandom_range(0, 99) < 11)
        begin
            // gaps up to a full scan so they end on every phase of the work
            gap = $urandom_range(1, 90);
            repeat (gap)
            begin
                @(negedge clk);
                start = 1'b0;
            end
        end
        @(negedge clk);
        start = 1'b1;
        func = f;
        pos_x = x;
        pos_y = y;
        odometer = odo;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        // transfer taken at this edge
        pending_reports.push_back(predict_report(f, x, y, odo));
        if (f == FUNC_ADD)
        begin
            n_adds++;
            if (pending_reports[$].table_full)
                n_dropped++;
        end
        else
        begin
            n_checks++;
            if (pending_reports[$].visited)
                n_hits++;
        end
    endtask

    // must follow a send with no clock edge in between
    task automatic wait_idle();
        @(negedge clk);
        start = 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_register(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        wait_idle();
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        case (idx)
            CFG_RADIUS: cur_radius = data[RAD_W-1:0];
            CFG_TRAVEL: cur_travel = data[TRAV_W-1:0];
            CFG_SIDE:   cur_side = data[0];
            default:    ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic test_empty_table();
        send_item(FUNC_CHECK, 16'sh0000, 16'sh0000, 32'h0000_0000);
        send_item(FUNC_CHECK, 16'sh8000, 16'sh7FFF, 32'hFFFF_FFFF);
    endtask

    task automatic test_travel_threshold();
        send_item(FUNC_ADD, 16'sh8000, 16'sh8000, 32'd1000);
        // travel equal to the minimum does not match, one more does
        send_item(FUNC_CHECK, 16'sh8000, 16'sh8000, 32'd1100);
        send_item(FUNC_CHECK, 16'sh8000, 16'sh8000, 32'd1101);
        // odometer behind the stored point
        send_item(FUNC_CHECK, 16'sh8000, 16'sh8000, 32'd500);
    endtask

    task automatic test_extreme_coords();
        set_register(CFG_RADIUS, 16'd1023);
        set_register(CFG_TRAVEL, 16'd0);
        set_register(CFG_SIDE, 16'd1);
        send_item(FUNC_ADD, 16'sh7FFF, 16'sh7FFF, 32'hFFFF_FFFF);
        send_item(FUNC_CHECK, 16'sh7FFF, 16'sh8000, 32'hFFFF_FFFF);
        send_item(FUNC_CHECK, 16'sh8000, 16'sh7FFF, 32'hFFFF_FFFF);
        send_item(FUNC_CHECK, 16'sh7FFF, 16'sh7FFF, 32'h0000_0000);
    endtask

    task automatic test_radius_boundary();
        set_register(CFG_RADIUS, 16'd5);
        set_register(CFG_SIDE, 16'd0);
        set_register(CFG_UNUSED, 16'hFFFF);
        send_item(FUNC_ADD, 16'sd100, 16'sd200, 32'd5000);
        // 3-4-5 lies exactly on the circle
        send_item(FUNC_CHECK, 16'sd103, 16'sd204, 32'd6000);
        send_item(FUNC_CHECK, 16'sd103, 16'sd205, 32'd6000);
        set_register(CFG_RADIUS, 16'd0);
        send_item(FUNC_CHECK, 16'sd100, 16'sd200, 32'd6000);
        send_item(FUNC_CHECK, 16'sd101, 16'sd200, 32'd6000);
        // two candidates, both within reach of the check
        send_item(FUNC_ADD, 16'sd100, 16'sd200, 32'd2000);
        send_item(FUNC_CHECK, 16'sd100, 16'sd200, 32'd9000);
    endtask

    task automatic test_long_travel();
        set_register(CFG_TRAVEL, 16'hFFFF);
        send_item(FUNC_CHECK, 16'sd100, 16'sd200, 32'd5000 + 32'd65535);
        send_item(FUNC_CHECK, 16'sd100, 16'sd200, 32'd5000 + 32'd65536);
    endtask

    task automatic walk_add();
        int ox;
        int oy;
        ox = int'($urandom_range(0, 400)) - 200;
        oy = int'($urandom_range(0, 400)) - 200;
        walk_x = walk_x + COORD_W'(ox);
        walk_y = walk_y + COORD_W'(oy);
        trip_mm = trip_mm + DIST_W'($urandom_range(0, 300));
        send_item(FUNC_ADD, walk_x, walk_y, trip_mm);
    endtask

    task automatic random_traffic(input int n);
        int i;
        int roll;
        int k;
        int rr;
        int ox;
        int oy;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [DIST_W-1:0] odo;
        for (i = 0; i < n; i++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 25)
            begin
                if ($urandom_range(0, 99) < 85)
                    walk_add();
                else
                    send_item(FUNC_ADD, COORD_W'($urandom), COORD_W'($urandom), $urandom);
            end
            else if (roll < 85 && mem_count > 0)
            begin
                // aim near a stored point, travel around the threshold
                k = $urandom_range(0, mem_count - 1);
                rr = int'(cur_radius) + 2;
                ox = int'($urandom_range(0, 2 * rr)) - rr;
                oy = int'($urandom_range(0, 2 * rr)) - rr;
                x = mem_x[k] + COORD_W'(ox);
                y = mem_y[k] + COORD_W'(oy);
                odo = mem_dist[k] + DIST_W'(cur_travel) + DIST_W'($urandom_range(0, 40))
                      - DIST_W'(8);
                send_item(FUNC_CHECK, x, y, odo);
            end
            else
            begin
                odo = ($urandom_range(0, 1) == 1) ? trip_mm : $urandom;
                send_item(FUNC_CHECK, COORD_W'($urandom), COORD_W'($urandom), odo);
            end
        end
    endtask

    task automatic test_random_traffic();
        int p;
        logic [CFG_W-1:0] data;
        set_register(CFG_RADIUS, CFG_W'(RADIUS_RST));
        set_register(CFG_TRAVEL, CFG_W'(TRAVEL_RST));
        set_register(CFG_SIDE, 16'd0);
        random_traffic(500);

        set_register(CFG_RADIUS, 16'd1023);
        set_register(CFG_TRAVEL, 16'd0);
        set_register(CFG_SIDE, 16'd1);
        no_idle = 1'b1;
        random_traffic(500);
        no_idle = 1'b0;

        set_register(CFG_RADIUS, 16'd0);
        set_register(CFG_TRAVEL, 16'hFFFF);
        random_traffic(400);

        for (p = 0; p < 4; p++)
        begin
            data = ($urandom_range(0, 1) == 1) ? CFG_W'($urandom) : CFG_W'($urandom_range(0, 60));
            set_register(CFG_RADIUS, data);
            set_register(CFG_TRAVEL, CFG_W'($urandom));
            set_register(CFG_SIDE, CFG_W'($urandom));
            random_traffic(150);
        end
    endtask

    task automatic test_dropped_add();
        while (mem_count < DEPTH)
            walk_add();
        walk_add();
        send_item(FUNC_ADD, 16'sh7FFF, 16'sh8000, 32'h0000_0000);
        send_item(FUNC_ADD, 16'sh8000, 16'sh7FFF, 32'hFFFF_FFFF);
        send_item(FUNC_CHECK, walk_x, walk_y, trip_mm + 32'd70000);
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        func = FUNC_ADD;
        pos_x = '0;
        pos_y = '0;
        odometer = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_RADIUS;
        cfg_data = '0;
        cycles = 0;
        mismatches = 0;
        n_results = 0;
        n_adds = 0;
        n_dropped = 0;
        n_checks = 0;
        n_hits = 0;
        no_idle = 1'b0;
        mem_count = 0;
        mem_closed = 1'b0;
        cur_radius = RADIUS_RST;
        cur_travel = TRAVEL_RST;
        cur_side = 1'b0;
        walk_x = '0;
        walk_y = '0;
        trip_mm = 32'd20000;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (3) @(posedge clk);

        test_empty_table();
        test_travel_threshold();
        test_extreme_coords();
        test_radius_boundary();
        test_long_travel();
        test_random_traffic();
        test_dropped_add();
        wait_idle();
        repeat (20) @(posedge clk);

        $display("covered %0d adds (%0d dropped on a full table) and %0d checks, %0d revisits",
                 n_adds, n_dropped, n_checks, n_hits);
        $display("%0d results compared, %0d mismatches, %0d left outstanding",
                 n_results, mismatches, pending_reports.size());
        if (mismatches == 0 && pending_reports.size() == 0)
            $display("tb_visited_point_loop_closure: clean");
        else
            $display("tb_visited_point_loop_closure: errors");
        $finish;
    end

endmodule
